[rtl/ldtw_pkg.sv]
// Shared types and constants for the two-wire LED driver writer.
// No dependencies; the other files that use it refer to it by scoped names.
package ldtw_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Command bytes of the bus sequence
  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_DISP  = 8'h88;
  localparam logic [7:0] CMD_OFF   = 8'h80;
  localparam logic [7:0] SEG_MASK  = 8'h7F;

  // Segment inputs on the request channel
  localparam int SEG_INPUTS = 4;

  // Configuration port
  localparam int          CFG_ADDR_W     = 3;
  localparam int          CFG_DATA_W     = 32;
  localparam logic        IDX_BRIGHTNESS = 1'b0;

  // One result transaction
  typedef struct packed {
    logic clk_out;
    logic dio_out;
    logic accepted;
    logic busy_res;
    logic done_res;
    logic success;
  } res_t;

endpackage

[rtl/ldtw_if.sv]
// Valid/ready channel interfaces for the request and result transactions.
// Depends on nothing; field widths follow the block's item definitions.
interface ldtw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] segment_0;
  logic [7:0] segment_1;
  logic [7:0] segment_2;
  logic [7:0] segment_3;
  logic       dio_in;

  modport source (output valid, req_type, segment_0, segment_1, segment_2, segment_3,
                  dio_in, input ready);
  modport sink   (input valid, req_type, segment_0, segment_1, segment_2, segment_3,
                  dio_in, output ready);
endinterface

interface ldtw_out_if;
  logic valid;
  logic ready;
  logic clk_out;
  logic dio_out;
  logic accepted;
  logic busy_res;
  logic done_res;
  logic success;

  modport source (output valid, clk_out, dio_out, accepted, busy_res, done_res, success,
                  input ready);
  modport sink   (input valid, clk_out, dio_out, accepted, busy_res, done_res, success,
                  output ready);
endinterface

[rtl/ldtw_cfg_regs.sv]
// APB-style configuration registers: the brightness level.
// Depends on ldtw_pkg for address and data widths.
module ldtw_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ldtw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ldtw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ldtw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [2:0]                        brightness
);

  logic [2:0] brightness_r;
  logic       sel_bright;

  // Register index is the word address
  assign sel_bright = (paddr[ldtw_pkg::CFG_ADDR_W-1] == ldtw_pkg::IDX_BRIGHTNESS);

  // Write during the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 3'd0;
    end else if (psel && penable && pwrite && sel_bright) begin
      brightness_r <= pwdata[2:0];
    end
  end

  // Read back, zero outside the register map
  always_comb begin
    prdata = '0;
    if (sel_bright) begin
      prdata[2:0] = brightness_r;
    end
  end

  assign pready     = 1'b1;
  assign brightness = brightness_r;

endmodule

[rtl/ldtw_seq.sv]
// Bus sequencer: one pin action per tick transaction, frame and byte tracking.
// Depends on ldtw_pkg for request codes, command bytes and the result type.
module ldtw_seq #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      step,
  input  logic [1:0]                                req_type,
  input  logic [ldtw_pkg::SEG_INPUTS-1:0][7:0]      seg_in,
  input  logic                                      dio_in,
  input  logic [2:0]                                brightness,
  output ldtw_pkg::res_t                            res
);

  // Frame phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_BITS  = 3'd2;
  localparam logic [2:0] PH_ACK   = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  localparam logic [2:0] FRAME_LEN_ADDR = 3'(DIGIT_COUNT + 1);

  logic [DIGIT_COUNT-1:0][6:0] store_r, store_nxt;
  logic       op_clear_r, op_clear_nxt;
  logic [1:0] trans_r, trans_nxt;
  logic [2:0] byte_r, byte_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] act_r, act_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       failed_r, failed_nxt;
  logic       busy_r, busy_nxt;
  logic       clk_lvl_r, clk_lvl_nxt;
  logic       dio_lvl_r, dio_lvl_nxt;
  logic       store_we;

  logic [6:0] seg_sel;
  logic [7:0] cur_byte;
  logic [2:0] byte_inc;
  logic [2:0] frame_len;
  logic       begin_en;
  logic [1:0] begin_t;
  logic       finish;
  logic       accepted;
  logic       done;
  logic       ok;

  // Pick the stored digit for the current byte position
  always_comb begin
    seg_sel = 7'd0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (byte_r == 3'(i + 1)) begin
        seg_sel = store_r[i];
      end
    end
  end

  // Byte on the wire for this transaction
  always_comb begin
    unique case (trans_r)
      2'd0:    cur_byte = ldtw_pkg::CMD_DATA;
      2'd1:    cur_byte = (byte_r == 3'd0) ? ldtw_pkg::CMD_ADDR : {1'b0, seg_sel};
      2'd2:    cur_byte = ldtw_pkg::CMD_DISP | {5'd0, brightness};
      default: cur_byte = ldtw_pkg::CMD_OFF;
    endcase
  end

  assign byte_inc  = byte_r + 3'd1;
  assign frame_len = (trans_r == 2'd1) ? FRAME_LEN_ADDR : 3'd1;

  // Next state for one accepted transaction
  always_comb begin
    op_clear_nxt = op_clear_r;
    trans_nxt    = trans_r;
    byte_nxt     = byte_r;
    phase_nxt    = phase_r;
    act_nxt      = act_r;
    bit_nxt      = bit_r;
    failed_nxt   = failed_r;
    busy_nxt     = busy_r;
    clk_lvl_nxt  = clk_lvl_r;
    dio_lvl_nxt  = dio_lvl_r;
    store_nxt    = store_r;
    store_we     = 1'b0;
    begin_en     = 1'b0;
    begin_t      = 2'd0;
    finish       = 1'b0;
    accepted     = 1'b0;
    done         = 1'b0;
    ok           = 1'b0;

    priority if (req_type == ldtw_pkg::REQ_TICK) begin
      if (busy_r) begin
        accepted = 1'b1;
        unique case (phase_r)
          PH_START: begin
            unique case (act_r)
              2'd0: dio_lvl_nxt = 1'b1;
              2'd1: clk_lvl_nxt = 1'b1;
              2'd2: dio_lvl_nxt = 1'b0;
              default: begin
                clk_lvl_nxt = 1'b0;
                phase_nxt   = PH_BITS;
                bit_nxt     = 3'd0;
              end
            endcase
            act_nxt = act_r + 2'd1;
          end
          PH_BITS: begin
            unique case (act_r)
              2'd0: begin
                dio_lvl_nxt = cur_byte[bit_r];
                act_nxt     = 2'd1;
              end
              2'd1: begin
                clk_lvl_nxt = 1'b1;
                act_nxt     = 2'd2;
              end
              default: begin
                clk_lvl_nxt = 1'b0;
                act_nxt     = 2'd0;
                if (bit_r == 3'd7) begin
                  bit_nxt   = 3'd0;
                  phase_nxt = PH_ACK;
                end else begin
                  bit_nxt = bit_r + 3'd1;
                end
              end
            endcase
          end
          PH_ACK: begin
            unique case (act_r)
              2'd0: begin
                dio_lvl_nxt = 1'b1;
                act_nxt     = 2'd1;
              end
              2'd1: begin
                clk_lvl_nxt = 1'b1;
                act_nxt     = 2'd2;
              end
              default: begin
                clk_lvl_nxt = 1'b0;
                act_nxt     = 2'd0;
                if (dio_in) begin
                  failed_nxt = 1'b1;
                  phase_nxt  = PH_STOP;
                end else begin
                  byte_nxt  = byte_inc;
                  phase_nxt = (byte_inc < frame_len) ? PH_BITS : PH_STOP;
                  bit_nxt   = 3'd0;
                end
              end
            endcase
          end
          default: begin
            // Stop condition, then open the next frame or finish the operation
            unique case (act_r)
              2'd0: clk_lvl_nxt = 1'b0;
              2'd1: dio_lvl_nxt = 1'b0;
              2'd2: clk_lvl_nxt = 1'b1;
              default: begin
                dio_lvl_nxt = 1'b1;
                priority if (trans_r == 2'd3) begin
                  finish = 1'b1;
                end else if (failed_r || trans_r == 2'd2) begin
                  if (op_clear_r) begin
                    begin_en = 1'b1;
                    begin_t  = 2'd3;
                  end else begin
                    finish = 1'b1;
                  end
                end else begin
                  begin_en = 1'b1;
                  begin_t  = trans_r + 2'd1;
                end
              end
            endcase
            act_nxt = act_r + 2'd1;
          end
        endcase

        if (finish) begin
          done      = 1'b1;
          ok        = !failed_nxt;
          busy_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
        end
      end
    end else if ((req_type == ldtw_pkg::REQ_WRITE || req_type == ldtw_pkg::REQ_CLEAR)
                 && !busy_r) begin
      // Latch the operation; the first pin action waits for the next tick
      accepted     = 1'b1;
      op_clear_nxt = (req_type == ldtw_pkg::REQ_CLEAR);
      store_we     = 1'b1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (i < ldtw_pkg::SEG_INPUTS && req_type == ldtw_pkg::REQ_WRITE) begin
          store_nxt[i] = seg_in[2'(i)][6:0] & ldtw_pkg::SEG_MASK[6:0];
        end else begin
          store_nxt[i] = 7'd0;
        end
      end
      failed_nxt = 1'b0;
      busy_nxt   = 1'b1;
      begin_en   = 1'b1;
      begin_t    = 2'd0;
    end

    // Open a new frame
    if (begin_en) begin
      trans_nxt = begin_t;
      byte_nxt  = 3'd0;
      bit_nxt   = 3'd0;
      act_nxt   = 2'd0;
      phase_nxt = PH_START;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_clear_r <= 1'b0;
      trans_r    <= 2'd0;
      byte_r     <= 3'd0;
      phase_r    <= PH_IDLE;
      act_r      <= 2'd0;
      bit_r      <= 3'd0;
      failed_r   <= 1'b0;
      busy_r     <= 1'b0;
      clk_lvl_r  <= 1'b1;
      dio_lvl_r  <= 1'b1;
    end else if (step) begin
      op_clear_r <= op_clear_nxt;
      trans_r    <= trans_nxt;
      byte_r     <= byte_nxt;
      phase_r    <= phase_nxt;
      act_r      <= act_nxt;
      bit_r      <= bit_nxt;
      failed_r   <= failed_nxt;
      busy_r     <= busy_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      dio_lvl_r  <= dio_lvl_nxt;
    end
  end

  // Segment store, written whole on every taken write or clear request
  always_ff @(posedge clk) begin
    if (step && store_we) begin
      store_r <= store_nxt;
    end
  end

  assign res.clk_out  = clk_lvl_nxt;
  assign res.dio_out  = dio_lvl_nxt;
  assign res.accepted = accepted;
  assign res.busy_res = busy_nxt;
  assign res.done_res = done;
  assign res.success  = ok;

endmodule

[rtl/led_driver_two_wire_writer.sv]
// Two-wire LED driver writer: takes one request or tick transaction per clock and
// returns one result transaction for each in the next cycle, from a result register.
// Throughput is one item per cycle, the sequencer stepping on each taken item; input
// stalls only while the result register holds a transaction the sink has not taken.
// Depends on ldtw_pkg, ldtw_if, ldtw_cfg_regs and ldtw_seq.
module led_driver_two_wire_writer #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ldtw_in_if.sink                           in_ch,
  ldtw_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ldtw_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ldtw_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ldtw_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic                                 in_ready;
  logic                                 step;
  logic [2:0]                           brightness;
  logic [ldtw_pkg::SEG_INPUTS-1:0][7:0] seg_in;
  ldtw_pkg::res_t                       res;
  ldtw_pkg::res_t                       res_r;
  logic                                 out_valid_r;

  // Accept while the result slot is free or draining
  assign in_ready = !out_valid_r || out_ch.ready;
  assign step     = in_ch.valid && in_ready;
  assign seg_in   = {in_ch.segment_3, in_ch.segment_2, in_ch.segment_1, in_ch.segment_0};

  ldtw_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .brightness (brightness)
  );

  ldtw_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .req_type   (in_ch.req_type),
    .seg_in     (seg_in),
    .dio_in     (in_ch.dio_in),
    .brightness (brightness),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.clk_out  = res_r.clk_out;
  assign out_ch.dio_out  = res_r.dio_out;
  assign out_ch.accepted = res_r.accepted;
  assign out_ch.busy_res = res_r.busy_res;
  assign out_ch.done_res = res_r.done_res;
  assign out_ch.success  = res_r.success;

endmodule

[rtl/ldtw_checker.sv]
// Port-level checks for the two-wire LED driver writer, bound to the top level.
// Depends only on the top level's ports.
module ldtw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic clk_out,
  input logic dio_out,
  input logic accepted,
  input logic busy_res,
  input logic done_res,
  input logic success
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({clk_out, dio_out, accepted,
                                                      busy_res, done_res, success}))
    else $error("result changed while stalled");

  // Take input whenever the result slot is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result slot");

  // A finishing tick is a taken action that leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> accepted && !busy_res)
    else $error("done without idle");

  // Success only comes with done
  a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && success |-> done_res)
    else $error("success without done");

  // Both lines are released while idle
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> clk_out && dio_out)
    else $error("line driven low while idle");

endmodule

bind led_driver_two_wire_writer ldtw_checker u_ldtw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .clk_out   (out_ch.clk_out),
  .dio_out   (out_ch.dio_out),
  .accepted  (out_ch.accepted),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .success   (out_ch.success)
);

[sim/tb.sv]
`timescale 1ns / 100ps

// Testbench for led_driver_two_wire_writer: request and tick transactions are checked
// against a built-in model of the bus sequencer, with random stalls on both channels.
// Depends on ldtw_pkg, the ldtw_in_if / ldtw_out_if interfaces and the block's RTL.
module tb;

  localparam int DIGITS         = 4;
  localparam int STORE_SLOTS    = 8;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [ldtw_pkg::CFG_ADDR_W-1:0] BRIGHT_ADDR =
    {ldtw_pkg::IDX_BRIGHTNESS, 2'b00};
  localparam int LONG_STALL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SEGMENT_QUOTA  = 250;
  localparam int SEGMENTS       = 6;

  typedef enum logic [2:0] {LP_IDLE, LP_START, LP_BITS, LP_ACK, LP_STOP} link_phase_e;

  typedef struct packed {
    logic [1:0]      req;
    logic [3:0][7:0] seg;
    logic            dio;
  } req_item_t;

  typedef struct packed {
    logic [STORE_SLOTS-1:0][6:0] seg;
    logic        clear_op;
    logic [1:0]  xfer;
    logic [2:0]  byte_idx;
    link_phase_e phase;
    logic [1:0]  act;
    logic [2:0]  bit_idx;
    logic        failed;
    logic        busy;
    logic        scl;
    logic        sda;
  } bus_state_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ldtw_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ldtw_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ldtw_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ldtw_in_if  in_ch ();
  ldtw_out_if out_ch ();

  led_driver_two_wire_writer #(.DIGIT_COUNT(DIGITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  req_item_t       pending_items[$];
  ldtw_pkg::res_t  expected_res[$];
  int              items_in_flight;
  bus_state_t      live_bus;
  bus_state_t      plan_bus;
  logic [2:0]      live_bright;
  logic [2:0]      plan_bright;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              stall_asks;
  int              stalls_served;
  int              stall_left;
  logic            req_taken;
  int              quiet_cycles;
  int              fail_count;
  int              results_seen;
  req_item_t       offer;
  req_item_t       seen;
  ldtw_pkg::res_t  got;
  ldtw_pkg::res_t  want;

  // Bus sequencer state right after reset: both lines released
  function automatic bus_state_t idle_bus();
    bus_state_t s;
    s = '0;
    s.phase = LP_IDLE;
    s.scl = 1'b1;
    s.sda = 1'b1;
    return s;
  endfunction

  // Byte currently on the wire for this frame
  function automatic logic [7:0] wire_byte(input bus_state_t s, input logic [2:0] bright);
    logic [2:0] slot;
    slot = s.byte_idx - 3'd1;
    case (s.xfer)
      2'd0: return ldtw_pkg::CMD_DATA;
      2'd1: return (s.byte_idx == 3'd0) ? ldtw_pkg::CMD_ADDR
                                        : ({1'b0, s.seg[slot]} & ldtw_pkg::SEG_MASK);
      2'd2: return ldtw_pkg::CMD_DISP | {5'd0, bright};
      default: return ldtw_pkg::CMD_OFF;
    endcase
  endfunction

  function automatic void open_frame(inout bus_state_t s, input logic [1:0] x);
    s.xfer = x;
    s.byte_idx = 3'd0;
    s.bit_idx = 3'd0;
    s.act = 2'd0;
    s.phase = LP_START;
  endfunction

  // Apply one transaction to the sequencer state and return the result it yields
  function automatic ldtw_pkg::res_t advance_bus(inout bus_state_t s, input req_item_t it,
                                                 input logic [2:0] bright);
    ldtw_pkg::res_t r;
    logic took;
    logic fin;
    logic [7:0] b;
    int frame_len;
    took = 1'b0;
    fin = 1'b0;
    if (it.req == ldtw_pkg::REQ_TICK) begin
      if (s.busy) begin
        took = 1'b1;
        case (s.phase)
          LP_START: begin
            case (s.act)
              2'd0: s.sda = 1'b1;
              2'd1: s.scl = 1'b1;
              2'd2: s.sda = 1'b0;
              default: s.scl = 1'b0;
            endcase
            if (s.act == 2'd3) begin
              s.phase = LP_BITS;
              s.bit_idx = 3'd0;
              s.act = 2'd0;
            end else begin
              s.act = s.act + 2'd1;
            end
          end
          LP_BITS: begin
            if (s.act == 2'd0) begin
              b = wire_byte(s, bright);
              s.sda = b[s.bit_idx];
              s.act = 2'd1;
            end else if (s.act == 2'd1) begin
              s.scl = 1'b1;
              s.act = 2'd2;
            end else begin
              s.scl = 1'b0;
              s.act = 2'd0;
              if (s.bit_idx == 3'd7) begin
                s.bit_idx = 3'd0;
                s.phase = LP_ACK;
              end else begin
                s.bit_idx = s.bit_idx + 3'd1;
              end
            end
          end
          LP_ACK: begin
            if (s.act == 2'd0) begin
              s.sda = 1'b1;
              s.act = 2'd1;
            end else if (s.act == 2'd1) begin
              s.scl = 1'b1;
              s.act = 2'd2;
            end else begin
              // Sample the acknowledge while dropping the clock
              s.scl = 1'b0;
              s.act = 2'd0;
              if (it.dio) begin
                s.failed = 1'b1;
                s.phase = LP_STOP;
              end else begin
                s.byte_idx = s.byte_idx + 3'd1;
                frame_len = (s.xfer == 2'd1) ? 1 + DIGITS : 1;
                s.phase = (int'(s.byte_idx) < frame_len) ? LP_BITS : LP_STOP;
                s.bit_idx = 3'd0;
              end
            end
          end
          default: begin
            case (s.act)
              2'd0: s.scl = 1'b0;
              2'd1: s.sda = 1'b0;
              2'd2: s.scl = 1'b1;
              default: s.sda = 1'b1;
            endcase
            // After the stop, pick the next frame or finish the operation
            if (s.act != 2'd3) begin
              s.act = s.act + 2'd1;
            end else if (s.xfer == 2'd3) begin
              fin = 1'b1;
            end else if (s.failed || s.xfer == 2'd2) begin
              if (s.clear_op) open_frame(s, 2'd3);
              else fin = 1'b1;
            end else begin
              open_frame(s, s.xfer + 2'd1);
            end
          end
        endcase
        if (fin) begin
          s.busy = 1'b0;
          s.phase = LP_IDLE;
        end
      end
    end else if (it.req != REQ_UNUSED && !s.busy) begin
      // Latch the operation; a clear loads blank digits
      took = 1'b1;
      s.clear_op = (it.req == ldtw_pkg::REQ_CLEAR);
      for (int i = 0; i < STORE_SLOTS; i++) begin
        s.seg[i] = (it.req == ldtw_pkg::REQ_WRITE && i < ldtw_pkg::SEG_INPUTS)
                   ? it.seg[i][6:0] : 7'd0;
      end
      s.failed = 1'b0;
      s.busy = 1'b1;
      open_frame(s, 2'd0);
    end
    r.clk_out  = s.scl;
    r.dio_out  = s.sda;
    r.accepted = took;
    r.busy_res = s.busy;
    r.done_res = fin;
    r.success  = fin & ~s.failed;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Input acceptance, result checking, brightness tracking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken <= in_ch.valid && in_ch.ready;
      if (psel && penable && pwrite && pready && paddr == BRIGHT_ADDR) begin
        live_bright <= pwdata[2:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.req = in_ch.req_type;
        seen.seg = {in_ch.segment_3, in_ch.segment_2, in_ch.segment_1, in_ch.segment_0};
        seen.dio = in_ch.dio_in;
        expected_res.push_back(advance_bus(live_bus, seen, live_bright));
        items_in_flight--;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.clk_out, out_ch.dio_out, out_ch.accepted,
               out_ch.busy_res, out_ch.done_res, out_ch.success};
        if (expected_res.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing expected: %06b",
                                 results_seen, got));
        end else begin
          want = expected_res.pop_front();
          if (got !== want) begin
            note_failure($sformatf({"result %0d mismatch (clk,dio,acc,busy,done,ok):",
                                    " expected %06b got %06b"}, results_seen, want, got));
          end
        end
        results_seen++;
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Request sender: hold the offered transaction until taken, idle at random
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || req_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = pending_items.pop_front();
        in_ch.req_type  <= offer.req;
        in_ch.segment_0 <= offer.seg[0];
        in_ch.segment_1 <= offer.seg[1];
        in_ch.segment_2 <= offer.seg[2];
        in_ch.segment_3 <= offer.seg[3];
        in_ch.dio_in    <= offer.dio;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_asks != stalls_served) begin
        stalls_served = stall_asks;
        stall_left = LONG_STALL;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Plan one transaction against the lookahead state and queue it for the sender
  task automatic queue_item(input logic [1:0] req, input logic [31:0] segs, input logic dio,
                            output logic took);
    req_item_t it;
    ldtw_pkg::res_t planned;
    it.req = req;
    it.seg = segs;
    it.dio = dio;
    planned = advance_bus(plan_bus, it, plan_bright);
    pending_items.push_back(it);
    items_in_flight++;
    took = planned.accepted;
  endtask

  task automatic wait_drained();
    while (items_in_flight != 0 || expected_res.size() != 0) @(negedge clk);
  endtask

  // Write the brightness register, then read it back
  task automatic set_brightness(input logic [2:0] level);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BRIGHT_ADDR;
    pwdata  <= ldtw_pkg::CFG_DATA_W'(level);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ldtw_pkg::CFG_DATA_W'(level)) begin
      note_failure($sformatf("brightness read-back: expected %0d got %0h", level, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    plan_bright = level;
  endtask

  // One write or clear with random content, run to completion; mostly acknowledged
  task automatic run_random_operation(inout int counted);
    logic took;
    int miss_pct;
    int pick;
    logic [1:0] req;
    pick = $urandom_range(99);
    miss_pct = (pick < 50) ? 0 : (pick < 80) ? 2 : 20;
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(3, 1)) begin
        queue_item(ldtw_pkg::REQ_TICK, $urandom, 1'($urandom_range(1)), took);
      end
    end
    if ($urandom_range(99) < 10) queue_item(REQ_UNUSED, $urandom, 1'($urandom_range(1)), took);
    req = ($urandom_range(99) < 60) ? ldtw_pkg::REQ_WRITE : ldtw_pkg::REQ_CLEAR;
    queue_item(req, $urandom, 1'($urandom_range(1)), took);
    counted += int'(took);
    while (plan_bus.busy) begin
      // Occasional request while busy, which must be refused
      if ($urandom_range(99) < 4) begin
        queue_item(2'($urandom_range(3, 1)), $urandom, 1'($urandom_range(1)), took);
      end
      queue_item(ldtw_pkg::REQ_TICK, $urandom, ($urandom_range(99) < miss_pct), took);
      counted += int'(took);
    end
  endtask

  // Reset, directed checks, then random segments under changing stall patterns
  initial begin
    logic took;
    int counted;
    bit paused;
    logic [2:0] level;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.req_type = ldtw_pkg::REQ_TICK;
    in_ch.segment_0 = '0;
    in_ch.segment_1 = '0;
    in_ch.segment_2 = '0;
    in_ch.segment_3 = '0;
    in_ch.dio_in = 1'b1;
    out_ch.ready = 1'b0;
    live_bus = idle_bus();
    plan_bus = idle_bus();
    live_bright = 3'd0;
    plan_bright = 3'd0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asks = 0;
    stalls_served = 0;
    stall_left = 0;
    req_taken = 1'b0;
    quiet_cycles = 0;
    fail_count = 0;
    results_seen = 0;
    items_in_flight = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle tick and unused code, then a write with every bit-7 case that loses
    // its first acknowledge, with requests arriving while busy
    queue_item(ldtw_pkg::REQ_TICK, $urandom, 1'b1, took);
    queue_item(REQ_UNUSED, 32'hFFFF_FFFF, 1'b0, took);
    queue_item(ldtw_pkg::REQ_TICK, $urandom, 1'b0, took);
    queue_item(ldtw_pkg::REQ_WRITE, 32'h007F_80FF, 1'b0, took);
    queue_item(ldtw_pkg::REQ_WRITE, 32'hFF80_7F00, 1'b1, took);
    queue_item(ldtw_pkg::REQ_CLEAR, $urandom, 1'b0, took);
    queue_item(REQ_UNUSED, $urandom, 1'b1, took);
    while (plan_bus.busy) queue_item(ldtw_pkg::REQ_TICK, $urandom, 1'b1, took);
    wait_drained();

    for (int k = 0; k < SEGMENTS; k++) begin
      level = (k == 0) ? 3'd7 : (k == 1) ? 3'd0 : 3'($urandom_range(7));
      set_brightness(level);
      send_idle_pct = (k < 2) ? 25 : (k < 4) ? 55 : 0;
      recv_idle_pct = (k < 2) ? 55 : (k < 4) ? 25 : 0;
      if (k == 0 || k == 3) stall_asks++;
      counted = 0;
      paused = 1'b0;
      while (counted < SEGMENT_QUOTA) begin
        // Hold the sender once per segment until every result is back
        if (!paused && counted >= SEGMENT_QUOTA / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        run_random_operation(counted);
      end
      wait_drained();
    end

    repeat (4) @(negedge clk);
    if (expected_res.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_res.size()));
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
